[hw/rtl/pwm_frequency_duty_meter_top_defines.svh]
// Assertion macros used by the PWM meter controller.
`ifndef PWM_FREQUENCY_DUTY_METER_TOP_DEFINES_SVH
`define PWM_FREQUENCY_DUTY_METER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and switched off while i_rst_n is low.
`define PFDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and switched off while i_rst_n is low.
`define PFDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pfdm_pkg.sv]
// Package with the shared widths, constants and controller/datapath structs.
`default_nettype none

package pfdm_pkg;

    // Default width of the capture timer.
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Field widths of the clock register and the result.
    localparam int unsigned CLK_W  = 27;
    localparam int unsigned DUTY_W = 7;

    // Reset value of the timer tick rate register.
    localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 27'd8000000;

    // Scale of the duty figure.
    localparam int unsigned PCT_SCALE = 100;

    // Width of the divider step counter; it must hold CLK_W itself.
    localparam int unsigned STEP_W = $clog2(CLK_W + 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_first;
        logic cap_fall;
        logic cap_third;
        logic start_freq;
        logic start_duty;
        logic save_freq;
        logic save_duty;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic order_ok;
        logic div_busy;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/pfdm_if.sv]
// Handshake interfaces for the edge event channel and the result channel.
`default_nettype none

// Edge events from the input-capture unit.
interface pfdm_edge_if #(
    parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] timestamp;
    logic                   rising;

    modport source (output valid, output timestamp, output rising, input ready);
    modport sink   (input valid, input timestamp, input rising, output ready);
endinterface

// Measurement results.
interface pfdm_res_if ();
    logic                              valid;
    logic                              ready;
    logic                              valid_res;
    logic [pfdm_pkg::CLK_W-1:0]        frequency_hz;
    logic [pfdm_pkg::DUTY_W-1:0]       duty_percent;

    modport source (output valid, output valid_res, output frequency_hz,
                    output duty_percent, input ready);
    modport sink   (input valid, input valid_res, input frequency_hz,
                    input duty_percent, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfdm_div.sv]
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module pfdm_div #(
    parameter int unsigned DEN_W  = pfdm_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned NUM_W  = pfdm_pkg::CLK_W,
    parameter int unsigned STEP_W = pfdm_pkg::STEP_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DEN_W-1:0]  i_rem_init,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [STEP_W-1:0] i_steps,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [NUM_W-1:0]       o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_rem_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // One trial subtraction: bring down the next dividend bit and compare.
    always_comb begin
        w_rem_sh = {r_rem, r_acc[NUM_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    // Step counter and busy/done flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and the shared dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_acc <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
            r_acc <= {r_acc[NUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

`default_nettype wire

[hw/rtl/pfdm_datapath.sv]
// Datapath: edge time registers, clock register, shared divider and result registers.
`default_nettype none

module pfdm_datapath #(
    parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pfdm_pkg::CLK_W-1:0]    i_cfg_wdata,
    input  wire logic [COUNT_WIDTH-1:0]        i_timestamp,
    input  wire pfdm_pkg::t_dp_cmd             i_cmd,
    output pfdm_pkg::t_dp_sts                  o_sts,
    output logic                               o_valid_res,
    output logic [pfdm_pkg::CLK_W-1:0]         o_frequency_hz,
    output logic [pfdm_pkg::DUTY_W-1:0]        o_duty_percent
);

    localparam int unsigned CLK_W  = pfdm_pkg::CLK_W;
    localparam int unsigned DUTY_W = pfdm_pkg::DUTY_W;
    localparam int unsigned STEP_W = pfdm_pkg::STEP_W;
    localparam int unsigned PROD_W = COUNT_WIDTH + DUTY_W;

    logic [CLK_W-1:0]       r_clock_hz;
    logic [COUNT_WIDTH-1:0] r_first;
    logic [COUNT_WIDTH-1:0] r_fall;
    logic [COUNT_WIDTH-1:0] r_period;
    logic [COUNT_WIDTH-1:0] r_high;
    logic                   r_res_ok;
    logic [CLK_W-1:0]       r_freq;
    logic [DUTY_W-1:0]      r_duty;
    logic                   r_out_ok;
    logic [CLK_W-1:0]       r_out_freq;
    logic [DUTY_W-1:0]      r_out_duty;

    logic                   w_order_ok;
    logic [PROD_W-1:0]      w_prod;
    logic                   w_div_start;
    logic [COUNT_WIDTH-1:0] w_rem_init;
    logic [CLK_W-1:0]       w_num;
    logic [STEP_W-1:0]      w_steps;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [CLK_W-1:0]       w_quot;

    // The first rise, the fall and the closing rise must be strictly increasing for a valid measurement.
    assign w_order_ok = (r_first < r_fall) && (r_fall < i_timestamp);

    // High time scaled by one hundred; below 128 periods, so the quotient fits seven bits.
    assign w_prod = {{DUTY_W{1'b0}}, r_high} * PROD_W'(pfdm_pkg::PCT_SCALE);

    // Divider set-up. The duty pass preloads the upper product bits, which are
    // already below the period, and then only needs seven steps.
    always_comb begin
        w_div_start = i_cmd.start_freq || i_cmd.start_duty;
        if (i_cmd.start_duty) begin
            w_rem_init = w_prod[PROD_W-1:DUTY_W];
            w_num      = {w_prod[DUTY_W-1:0], {(CLK_W-DUTY_W){1'b0}}};
            w_steps    = STEP_W'(DUTY_W);
        end else begin
            w_rem_init = '0;
            w_num      = r_clock_hz;
            w_steps    = STEP_W'(CLK_W);
        end
    end

    pfdm_div #(
        .DEN_W  (COUNT_WIDTH),
        .NUM_W  (CLK_W),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_rem_init),
        .i_num      (w_num),
        .i_den      (r_period),
        .i_steps    (w_steps),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Timer tick rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= pfdm_pkg::CLOCK_HZ_RST;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_wdata;
        end
    end

    // Edge times, period and high time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_first) begin
            r_first <= i_timestamp;
        end
        if (i_cmd.cap_fall) begin
            r_fall <= i_timestamp;
        end
        if (i_cmd.cap_third) begin
            r_period <= i_timestamp - r_first;
            r_high   <= r_fall - r_first;
        end
    end

    // Working result; an out-of-order measurement reports zeros.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_third) begin
            r_res_ok <= w_order_ok;
            if (!w_order_ok) begin
                r_freq <= '0;
                r_duty <= '0;
            end
        end
        if (i_cmd.save_freq) begin
            r_freq <= w_quot;
        end
        if (i_cmd.save_duty) begin
            r_duty <= w_quot[DUTY_W-1:0];
        end
    end

    // Output item register, so the next measurement can start while it waits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ok   <= r_res_ok;
            r_out_freq <= r_freq;
            r_out_duty <= r_duty;
        end
    end

    assign o_sts.order_ok = w_order_ok;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;

    assign o_valid_res    = r_out_ok;
    assign o_frequency_hz = r_out_freq;
    assign o_duty_percent = r_out_duty;

endmodule

`default_nettype wire

[hw/rtl/pfdm_ctrl.sv]
// Controller: edge phase tracking and the measurement sequence.
`default_nettype none
`include "pwm_frequency_duty_meter_top_defines.svh"

module pfdm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_edge_valid,
    input  wire logic              i_edge_rising,
    output logic                   o_edge_ready,
    input  wire logic              i_res_ready,
    output logic                   o_res_valid,
    output pfdm_pkg::t_dp_cmd      o_cmd,
    input  wire pfdm_pkg::t_dp_sts i_sts
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FREQ_GO  = 3'd1;
    localparam logic [2:0] S_FREQ_RUN = 3'd2;
    localparam logic [2:0] S_DUTY_GO  = 3'd3;
    localparam logic [2:0] S_DUTY_RUN = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // Edge phases: which edge is awaited next.
    localparam logic [1:0] PH_RISE1 = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_RISE2 = 2'd2;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic       r_out_valid;

    logic       w_accept;
    logic       w_slot_free;

    assign o_edge_ready = (r_state == S_IDLE);
    assign w_accept     = i_edge_valid && o_edge_ready;
    assign w_slot_free  = !r_out_valid || i_res_ready;

    // Next state, next phase and datapath commands.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (r_phase)
                        PH_FALL: begin
                            if (!i_edge_rising) begin
                                o_cmd.cap_fall = 1'b1;
                                n_phase        = PH_RISE2;
                            end
                        end
                        PH_RISE2: begin
                            if (i_edge_rising) begin
                                o_cmd.cap_third = 1'b1;
                                n_phase         = PH_RISE1;
                                n_state         = i_sts.order_ok ? S_FREQ_GO : S_DONE;
                            end
                        end
                        default: begin
                            // Awaiting the first rising edge; the spare code acts the same.
                            if (i_edge_rising) begin
                                o_cmd.cap_first = 1'b1;
                                n_phase         = PH_FALL;
                            end else begin
                                n_phase = PH_RISE1;
                            end
                        end
                    endcase
                end
            end
            S_FREQ_GO: begin
                o_cmd.start_freq = 1'b1;
                n_state          = S_FREQ_RUN;
            end
            S_FREQ_RUN: begin
                if (i_sts.div_done) begin
                    o_cmd.save_freq = 1'b1;
                    n_state         = S_DUTY_GO;
                end
            end
            S_DUTY_GO: begin
                o_cmd.start_duty = 1'b1;
                n_state          = S_DUTY_RUN;
            end
            S_DUTY_RUN: begin
                if (i_sts.div_done) begin
                    o_cmd.save_duty = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, phase and output item flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_RISE1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;

    // Checks on the sequence.
    `PFDM_ASSERT_NOW(a_busy_in_run, i_sts.div_busy, (r_state == S_FREQ_RUN) || (r_state == S_DUTY_RUN), "divider busy outside a run state")
    `PFDM_ASSERT_NEXT(a_third_rearms, w_accept && (r_phase == PH_RISE2) && i_edge_rising, (r_phase == PH_RISE1) && (r_state != S_IDLE), "closing edge did not rearm")
    `PFDM_ASSERT_NEXT(a_bad_order_no_div, o_cmd.cap_third && !i_sts.order_ok, r_state == S_DONE, "unordered edges started a division")
    `PFDM_ASSERT_NOW(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_res_ready, "result overwritten before it was taken")

endmodule

`default_nettype wire

[hw/rtl/pwm_frequency_duty_meter_top.sv]
// Top level of the PWM frequency and duty meter.
//
//   Channel   Direction  Handshake      Item
//   i_edge    in         valid/ready    timestamp, rising
//   o_res     out        valid/ready    valid_res, frequency_hz, duty_percent
//   i_cfg_*   in         write enable   clock_hz
//
// An edge that does not close a measurement leaves i_edge ready.
// A closing edge with ordered counts holds i_edge off through a start, a 27-step divider
// pass and a save for the frequency, the same with 7 steps for the duty, and a load.
// A closing edge with unordered counts holds i_edge off only for the load.
// While the previous result still waits at o_res, the sequence holds before its load cycle.
// Reset is synchronous and active low; it rearms the edge phase and empties o_res.
`default_nettype none

module pwm_frequency_duty_meter_top #(
    parameter int unsigned COUNT_WIDTH = pfdm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pfdm_pkg::CLK_W-1:0] i_cfg_wdata,
    pfdm_edge_if.sink                       i_edge,
    pfdm_res_if.source                      o_res
);

    pfdm_pkg::t_dp_cmd          w_cmd;
    pfdm_pkg::t_dp_sts          w_sts;
    logic                       w_edge_ready;
    logic                       w_res_valid;
    logic [COUNT_WIDTH-1:0]     w_timestamp;

    assign w_timestamp  = i_edge.timestamp;
    assign i_edge.ready = w_edge_ready;
    assign o_res.valid  = w_res_valid;

    // Sequencer.
    pfdm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_edge_valid  (i_edge.valid),
        .i_edge_rising (i_edge.rising),
        .o_edge_ready  (w_edge_ready),
        .i_res_ready   (o_res.ready),
        .o_res_valid   (w_res_valid),
        .o_cmd         (w_cmd),
        .i_sts         (w_sts)
    );

    // Edge registers, divider and result registers.
    pfdm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_timestamp    (w_timestamp),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_valid_res    (o_res.valid_res),
        .o_frequency_hz (o_res.frequency_hz),
        .o_duty_percent (o_res.duty_percent)
    );

endmodule

`default_nettype wire

[tb/sv/pwm_frequency_duty_meter_top_test.sv]
// Self-checking testbench for the PWM frequency and duty meter top level.
`timescale 1ns / 100ps

module pwm_frequency_duty_meter_top_test;

    localparam int unsigned CLK_W        = pfdm_pkg::CLK_W;
    localparam int unsigned DUTY_W       = pfdm_pkg::DUTY_W;
    localparam int unsigned TS_W         = pfdm_pkg::COUNT_WIDTH_DEF;
    localparam int unsigned TS_MAX       = (1 << TS_W) - 1;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned ITEMS_PHASE  = 280;
    localparam int unsigned NUM_PHASES   = 6;

    // Progress through one measurement.
    typedef enum logic [1:0] {
        AWAIT_FIRST_RISE = 2'd0,
        AWAIT_FALL       = 2'd1,
        AWAIT_CLOSE_RISE = 2'd2
    } t_meter_phase;

    // One measurement result as it appears on o_res.
    typedef struct packed {
        logic              valid_res;
        logic [CLK_W-1:0]  frequency_hz;
        logic [DUTY_W-1:0] duty_percent;
    } t_meter_result;

    // Tracks the meter state, predicts each result and checks what arrives.
    class t_meter_scoreboard;
        logic [CLK_W-1:0] tick_rate;
        t_meter_phase     await_state;
        logic [TS_W-1:0]  rise_stamp;
        logic [TS_W-1:0]  fall_stamp;
        t_meter_result    pending_results[$];
        int unsigned      mismatches;

        function new();
            tick_rate   = pfdm_pkg::CLOCK_HZ_RST;
            await_state = AWAIT_FIRST_RISE;
            rise_stamp  = '0;
            fall_stamp  = '0;
            mismatches  = 0;
        endfunction

        function void set_tick_rate(logic [CLK_W-1:0] value);
            tick_rate = value;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Notes an accepted edge; returns 1 when the edge had any effect.
        function bit note_edge(logic [TS_W-1:0] stamp, logic rising);
            t_meter_result res;
            int unsigned   period;
            int unsigned   high_ticks;
            case (await_state)
                AWAIT_FALL: begin
                    if (rising)
                        return 1'b0;
                    fall_stamp  = stamp;
                    await_state = AWAIT_CLOSE_RISE;
                    return 1'b1;
                end
                AWAIT_CLOSE_RISE: begin
                    if (!rising)
                        return 1'b0;
                    await_state = AWAIT_FIRST_RISE;
                    if (rise_stamp < fall_stamp && fall_stamp < stamp) begin
                        period           = int'(stamp) - int'(rise_stamp);
                        high_ticks       = int'(fall_stamp) - int'(rise_stamp);
                        res.valid_res    = 1'b1;
                        res.frequency_hz = CLK_W'(int'(tick_rate) / period);
                        res.duty_percent =
                            DUTY_W'((high_ticks * pfdm_pkg::PCT_SCALE) / period);
                    end else begin
                        res = '0;
                    end
                    pending_results.push_back(res);
                    return 1'b1;
                end
                default: begin
                    if (!rising)
                        return 1'b0;
                    rise_stamp  = stamp;
                    await_state = AWAIT_FALL;
                    return 1'b1;
                end
            endcase
        endfunction

        // Compares an accepted result with the oldest prediction.
        function void check_result(logic valid_res, logic [CLK_W-1:0] frequency_hz,
                                   logic [DUTY_W-1:0] duty_percent);
            t_meter_result exp_res;
            if (pending_results.size() == 0) begin
                $error("unexpected result: valid_res %0d, frequency_hz %0d, duty_percent %0d",
                       valid_res, frequency_hz, duty_percent);
                mismatches++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (valid_res !== exp_res.valid_res) begin
                $error("valid_res: expected %0d, got %0d", exp_res.valid_res, valid_res);
                mismatches++;
            end
            if (frequency_hz !== exp_res.frequency_hz) begin
                $error("frequency_hz: expected %0d, got %0d", exp_res.frequency_hz, frequency_hz);
                mismatches++;
            end
            if (duty_percent !== exp_res.duty_percent) begin
                $error("duty_percent: expected %0d, got %0d", exp_res.duty_percent, duty_percent);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CLK_W-1:0] i_cfg_wdata;

    pfdm_edge_if #(.COUNT_WIDTH(TS_W)) ev_if ();
    pfdm_res_if                        res_if ();

    t_meter_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       effective_edges;

    pwm_frequency_duty_meter_top #(
        .COUNT_WIDTH (TS_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_edge      (ev_if),
        .o_res       (res_if)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // The result side stalls at random on the falling edge.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
    end

    // Every result taken at a rising edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.valid_res, res_if.frequency_hz, res_if.duty_percent);
    end

    // Presents one edge after a random gap and waits until it is taken.
    task automatic send_edge(input logic [TS_W-1:0] stamp, input logic rising);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            ev_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        ev_if.valid     <= 1'b1;
        ev_if.timestamp <= stamp;
        ev_if.rising    <= rising;
        do
            @(posedge i_clk);
        while (!ev_if.ready);
        if (sb.note_edge(stamp, rising))
            effective_edges++;
    endtask

    task automatic send_triplet(input logic [TS_W-1:0] t1, input logic [TS_W-1:0] t2,
                                input logic [TS_W-1:0] t3);
        send_edge(t1, 1'b1);
        send_edge(t2, 1'b0);
        send_edge(t3, 1'b1);
    endtask

    // Lowers valid, lets every result arrive, then waits out any work still in flight.
    task automatic settle_meter();
        @(negedge i_clk);
        ev_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tick_rate(input logic [CLK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_tick_rate(value);
    endtask

    // Random traffic: mostly well-formed measurements, some broken ones and noise.
    task automatic run_random(input int unsigned quota);
        int unsigned kind;
        int unsigned t1;
        int unsigned t2;
        int unsigned t3;
        int unsigned target;
        target = effective_edges + quota;
        while (effective_edges < target) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                if ($urandom_range(3) == 0) begin
                    t1 = $urandom_range(65000);
                    t2 = t1 + $urandom_range(40, 1);
                    t3 = t2 + $urandom_range(400, 1);
                end else begin
                    t1 = $urandom_range(TS_MAX - 2);
                    t2 = $urandom_range(TS_MAX - 1, t1 + 1);
                    t3 = $urandom_range(TS_MAX, t2 + 1);
                end
                send_edge(TS_W'(t1), 1'b1);
                // A stray edge of the wrong polarity now and then.
                if ($urandom_range(4) == 0)
                    send_edge(TS_W'($urandom), 1'b1);
                send_edge(TS_W'(t2), 1'b0);
                if ($urandom_range(4) == 0)
                    send_edge(TS_W'($urandom), 1'b0);
                send_edge(TS_W'(t3), 1'b1);
            end else if (kind < 80) begin
                send_triplet(TS_W'($urandom), TS_W'($urandom), TS_W'($urandom));
            end else if (kind < 88) begin
                // Equal counts somewhere in the triplet.
                t1 = $urandom_range(TS_MAX - 1);
                t3 = $urandom_range(TS_MAX, t1 + 1);
                if ($urandom_range(1) == 0)
                    send_triplet(TS_W'(t1), TS_W'(t1), TS_W'(t3));
                else
                    send_triplet(TS_W'(t1), TS_W'(t3), TS_W'(t3));
            end else begin
                send_edge(TS_W'($urandom), 1'(($urandom)));
            end
        end
    endtask

    // Run time limit.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Reset, directed cases, then random phases over several tick rates.
    initial begin
        logic [CLK_W-1:0] rate;
        sb              = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        ev_if.valid     = 1'b0;
        ev_if.timestamp = '0;
        ev_if.rising    = 1'b0;
        send_idle_pct   = 20;
        recv_idle_pct   = 63;
        effective_edges = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed cases under the reset tick rate.
        send_triplet(16'd0, 16'd1, 16'd2);
        // Edges of the wrong polarity in each phase are ignored.
        send_edge(16'd50, 1'b0);
        send_edge(16'd100, 1'b1);
        send_edge(16'd200, 1'b1);
        send_edge(16'd300, 1'b0);
        send_edge(16'd400, 1'b0);
        send_edge(16'd500, 1'b1);
        // Longest period, with the highest and lowest duty.
        send_triplet(16'd0, 16'hFFFE, 16'hFFFF);
        send_triplet(16'd0, 16'd1, 16'hFFFF);
        // Unordered edges: equal counts, a reversed pair and timer overflow.
        send_triplet(16'd100, 16'd100, 16'd200);
        send_triplet(16'd500, 16'd600, 16'd600);
        send_triplet(16'd300, 16'd200, 16'd400);
        send_triplet(16'hFFFF, 16'd0, 16'd1);
        settle_meter();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       rate = CLK_W'(1);
                1:       rate = CLK_W'(100000000);
                2:       rate = '0;
                5:       rate = pfdm_pkg::CLOCK_HZ_RST;
                default: rate = CLK_W'($urandom_range(100000000, 1));
            endcase
            if (p < 2) begin
                send_idle_pct = 20;
                recv_idle_pct = 63;
            end else if (p < 4) begin
                send_idle_pct = 63;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_tick_rate(rate);
            run_random(ITEMS_PHASE);
            settle_meter();
        end

        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pfdm_pkg.sv
hw/rtl/pfdm_if.sv
hw/rtl/pfdm_div.sv
hw/rtl/pfdm_datapath.sv
hw/rtl/pfdm_ctrl.sv
hw/rtl/pwm_frequency_duty_meter_top.sv
tb/sv/pwm_frequency_duty_meter_top_test.sv
